// ===== rtl/csti_pkg.sv =====
`timescale 1ns / 1ps
package csti_pkg;
  localparam int TABLE_DEPTH = 1024;
  localparam int VALUE_BITS  = 32;
  localparam int FRAC_BITS   = 16;
  localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
  localparam int PTS_BITS    = ADDR_BITS + 1;
  localparam int TOTAL_BITS  = VALUE_BITS + 2;
  localparam int LANES       = 4;
  localparam int LANE_BITS   = $clog2(LANES);
  localparam int CNT_BITS    = $clog2(FRAC_BITS);
  localparam int ROW_BITS    = VALUE_BITS * LANES;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_RD_G0,
    CMD_RD_GN,
    CMD_CHECK,
    CMD_SEARCH_RD,
    CMD_SEARCH_CMP,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_RD_LO,
    CMD_RD_HI,
    CMD_CAP_HI,
    CMD_BLEND,
    CMD_SUM
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_query;
    logic clamp_hit;
    logic adjacent;
    logic div_last;
    logic lane_last;
    logic out_free;
  } dp_status_t;
endpackage

// ===== rtl/csti_ram.sv =====
`timescale 1ns / 1ps
module csti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/csti_ctrl.sv =====
`timescale 1ns / 1ps
module csti_ctrl
  import csti_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t sts,
  output dp_cmd_t    cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_G0, S_GN, S_CHK, S_SRCH, S_SCMP, S_DIVI, S_DIV,
    S_RLO, S_RHI, S_CAPH, S_BLD, S_SUM
  } state_t;

  state_t state;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd.op = CMD_NONE;
    unique case (state)
      S_IDLE: if (in_valid) cmd.op = CMD_ACCEPT;
      S_G0:   cmd.op = CMD_RD_G0;
      S_GN:   cmd.op = CMD_RD_GN;
      S_CHK:  cmd.op = CMD_CHECK;
      S_SRCH: if (!sts.adjacent) cmd.op = CMD_SEARCH_RD;
      S_SCMP: cmd.op = CMD_SEARCH_CMP;
      S_DIVI: cmd.op = CMD_DIV_INIT;
      S_DIV:  cmd.op = CMD_DIV_STEP;
      S_RLO:  cmd.op = CMD_RD_LO;
      S_RHI:  cmd.op = CMD_RD_HI;
      S_CAPH: cmd.op = CMD_CAP_HI;
      S_BLD:  cmd.op = CMD_BLEND;
      S_SUM:  if (sts.out_free) cmd.op = CMD_SUM;
      default: cmd.op = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid && sts.is_query) state <= S_G0;
        S_G0:   state <= S_GN;
        S_GN:   state <= S_CHK;
        S_CHK:  state <= sts.clamp_hit ? S_RLO : S_SRCH;
        S_SRCH: state <= sts.adjacent ? S_DIVI : S_SCMP;
        S_SCMP: state <= S_SRCH;
        S_DIVI: state <= S_DIV;
        S_DIV:  if (sts.div_last) state <= S_RLO;
        S_RLO:  state <= S_RHI;
        S_RHI:  state <= S_CAPH;
        S_CAPH: state <= S_BLD;
        S_BLD:  if (sts.lane_last) state <= S_SUM;
        S_SUM:  if (sts.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  ast_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == CMD_ACCEPT) |-> (state == S_IDLE && !in_stall))
    else $error("request taken outside idle");
  ast_query_starts: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == CMD_ACCEPT && sts.is_query) |=> (state == S_G0))
    else $error("query did not start search");
  ast_sum_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM && !sts.out_free) |=> (state == S_SUM))
    else $error("result left before output register freed");
endmodule

// ===== rtl/csti_dp.sv =====
`timescale 1ns / 1ps
module csti_dp
  import csti_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  dp_cmd_t                cmd,
  output dp_status_t             sts,
  input  logic                   cfg_valid,
  input  logic [PTS_BITS-1:0]    cfg_data,
  input  logic                   opcode,
  input  logic [ADDR_BITS-1:0]   row_index,
  input  logic [VALUE_BITS-1:0]  energy,
  input  logic [VALUE_BITS-1:0]  in_coherent,
  input  logic [VALUE_BITS-1:0]  in_incoherent,
  input  logic [VALUE_BITS-1:0]  in_photoelectric,
  input  logic [VALUE_BITS-1:0]  in_pair,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VALUE_BITS-1:0]  out_coherent,
  output logic [VALUE_BITS-1:0]  out_incoherent,
  output logic [VALUE_BITS-1:0]  out_photoelectric,
  output logic [VALUE_BITS-1:0]  out_pair,
  output logic [TOTAL_BITS-1:0]  out_total,
  output logic                   clamped
);
  logic [PTS_BITS-1:0]   points;
  logic [ADDR_BITS-1:0]  last_row;
  logic [VALUE_BITS-1:0] e;
  logic [VALUE_BITS-1:0] g0, glo, ghi, den;
  logic [VALUE_BITS:0]   rem;
  logic [FRAC_BITS-1:0]  t;
  logic [CNT_BITS-1:0]   cnt;
  logic [ADDR_BITS-1:0]  lo, hi, mid;
  logic [ADDR_BITS-1:0]  mid_next;
  logic [LANE_BITS-1:0]  lane;
  logic                  clamp;
  logic [ROW_BITS-1:0]   ylo, yhi;
  logic [VALUE_BITS-1:0] res [LANES];

  logic                  ram_we;
  logic [ADDR_BITS-1:0]  ram_addr;
  logic [VALUE_BITS-1:0] grid_rdata;
  logic [ROW_BITS-1:0]   curve_rdata, curve_wdata;

  logic [VALUE_BITS:0]   rem_sh;
  logic                  rem_ge;
  logic [VALUE_BITS-1:0] y0, y1, d, delta;
  logic [VALUE_BITS+FRAC_BITS-1:0] prod;

  // points_in_use held to [2, TABLE_DEPTH]
  always_comb begin
    if (points < PTS_BITS'(2)) last_row = ADDR_BITS'(1);
    else if (points > PTS_BITS'(TABLE_DEPTH)) last_row = ADDR_BITS'(TABLE_DEPTH - 1);
    else last_row = ADDR_BITS'(points - PTS_BITS'(1));
  end

  assign mid_next    = lo + ((hi - lo) >> 1);
  assign curve_wdata = {in_pair, in_photoelectric, in_incoherent, in_coherent};
  assign ram_we      = (cmd.op == CMD_ACCEPT) && (opcode == OP_LOAD);

  always_comb begin
    unique case (cmd.op)
      CMD_ACCEPT:    ram_addr = row_index;
      CMD_RD_GN:     ram_addr = last_row;
      CMD_SEARCH_RD: ram_addr = mid_next;
      CMD_RD_LO:     ram_addr = lo;
      CMD_RD_HI:     ram_addr = hi;
      default:       ram_addr = '0;
    endcase
  end

  csti_ram #(.WIDTH(VALUE_BITS), .DEPTH(TABLE_DEPTH)) u_grid (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(energy), .rdata(grid_rdata)
  );
  csti_ram #(.WIDTH(ROW_BITS), .DEPTH(TABLE_DEPTH)) u_curves (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(curve_wdata), .rdata(curve_rdata)
  );

  assign rem_sh = {rem[VALUE_BITS-1:0], 1'b0};
  assign rem_ge = rem_sh >= {1'b0, den};

  assign y0    = ylo[lane*VALUE_BITS +: VALUE_BITS];
  assign y1    = yhi[lane*VALUE_BITS +: VALUE_BITS];
  assign d     = (y1 >= y0) ? (y1 - y0) : (y0 - y1);
  assign prod  = (VALUE_BITS+FRAC_BITS)'(d) * (VALUE_BITS+FRAC_BITS)'(t);
  assign delta = prod[VALUE_BITS+FRAC_BITS-1:FRAC_BITS];

  assign sts.is_query  = (opcode == OP_QUERY);
  assign sts.clamp_hit = (e <= g0) || (e >= grid_rdata);
  assign sts.adjacent  = (hi - lo) <= ADDR_BITS'(1);
  assign sts.div_last  = (cnt == CNT_BITS'(FRAC_BITS - 1));
  assign sts.lane_last = (lane == LANE_BITS'(LANES - 1));
  assign sts.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      points <= PTS_BITS'(2);
    end else if (cfg_valid) begin
      points <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CMD_ACCEPT: e <= energy;
      CMD_RD_GN:  g0 <= grid_rdata;
      CMD_CHECK: begin
        glo <= g0;
        ghi <= grid_rdata;
        t   <= '0;
        if (e <= g0) begin
          lo <= '0; hi <= '0; clamp <= 1'b1;
        end else if (e >= grid_rdata) begin
          lo <= last_row; hi <= last_row; clamp <= 1'b1;
        end else begin
          lo <= '0; hi <= last_row; clamp <= 1'b0;
        end
      end
      CMD_SEARCH_RD: mid <= mid_next;
      CMD_SEARCH_CMP: begin
        if (grid_rdata <= e) begin
          lo <= mid; glo <= grid_rdata;
        end else begin
          hi <= mid; ghi <= grid_rdata;
        end
      end
      CMD_DIV_INIT: begin
        rem <= {1'b0, e - glo};
        den <= ghi - glo;
        cnt <= '0;
      end
      CMD_DIV_STEP: begin
        rem <= rem_ge ? (rem_sh - {1'b0, den}) : rem_sh;
        t   <= {t[FRAC_BITS-2:0], rem_ge};
        cnt <= cnt + CNT_BITS'(1);
      end
      CMD_RD_HI:  ylo <= curve_rdata;
      CMD_CAP_HI: begin
        yhi  <= curve_rdata;
        lane <= '0;
      end
      CMD_BLEND: begin
        res[lane] <= (y1 >= y0) ? (y0 + delta) : (y0 - delta);
        lane      <= lane + LANE_BITS'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == CMD_SUM) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_SUM) begin
      out_coherent      <= res[0];
      out_incoherent    <= res[1];
      out_photoelectric <= res[2];
      out_pair          <= res[3];
      out_total         <= TOTAL_BITS'(res[0]) + TOTAL_BITS'(res[1])
                         + TOTAL_BITS'(res[2]) + TOTAL_BITS'(res[3]);
      clamped           <= clamp;
    end
  end

  ast_search_open: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == CMD_SEARCH_RD) |-> (hi > lo + ADDR_BITS'(1)))
    else $error("search probed a closed interval");
  ast_div_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == CMD_DIV_STEP) |-> (rem < {1'b0, den}))
    else $error("division remainder out of range");
  ast_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == CMD_SUM) |-> (!out_valid || !out_stall))
    else $error("held result overwritten");
endmodule

// ===== rtl/cross_section_table_interpolator.sv =====
`timescale 1ns / 1ps
// Cross-section table interpolator.
// Input channel (in_valid / in_stall): opcode 0 loads one row (grid energy
// plus four curve values) at row_index; opcode 1 queries at energy.
// A load gives no result. A query binary-searches the grid through the grid
// RAM port (10 halvings over 1024 rows), runs a restoring divide for the
// 16-bit fraction, reads the two curve rows and blends the four curves on
// one shared multiplier, one curve a cycle. An energy at or beyond either
// grid end skips the search and divide and sets clamped.
// Output channel (out_valid / out_stall): the result sits in an output
// register; while the receiver stalls, the next request is still taken and
// worked on, and only its final write-back waits for the register to free.
// Config channel: cfg_ready is always high; write points_in_use only when idle.
// Reset (rst, synchronous) sets points_in_use to 2 and empties the output;
// table contents are undefined until loaded.
module cross_section_table_interpolator
  import csti_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [PTS_BITS-1:0]   cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  opcode,
  input  logic [ADDR_BITS-1:0]  row_index,
  input  logic [VALUE_BITS-1:0] energy,
  input  logic [VALUE_BITS-1:0] in_coherent,
  input  logic [VALUE_BITS-1:0] in_incoherent,
  input  logic [VALUE_BITS-1:0] in_photoelectric,
  input  logic [VALUE_BITS-1:0] in_pair,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VALUE_BITS-1:0] out_coherent,
  output logic [VALUE_BITS-1:0] out_incoherent,
  output logic [VALUE_BITS-1:0] out_photoelectric,
  output logic [VALUE_BITS-1:0] out_pair,
  output logic [TOTAL_BITS-1:0] out_total,
  output logic                  clamped
);
  dp_cmd_t    cmd;
  dp_status_t sts;

  assign cfg_ready = 1'b1;

  csti_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .cmd(cmd)
  );

  csti_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_valid(cfg_valid), .cfg_data(cfg_data),
    .opcode(opcode), .row_index(row_index), .energy(energy),
    .in_coherent(in_coherent), .in_incoherent(in_incoherent),
    .in_photoelectric(in_photoelectric), .in_pair(in_pair),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_coherent(out_coherent), .out_incoherent(out_incoherent),
    .out_photoelectric(out_photoelectric), .out_pair(out_pair),
    .out_total(out_total), .clamped(clamped)
  );
endmodule
